// ===== sv/pdcm_pkg.sv =====
// ----------------------------------------------------------------------------
// pdcm_pkg
// Shared types, mode codes and the hue mapping of the display color mapper.
// ----------------------------------------------------------------------------
package pdcm_pkg;

	localparam int unsigned WORD_W = 16;
	localparam int unsigned MODE_W = 3;
	localparam int unsigned SECTOR_W = 3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [SECTOR_W-1:0] sector_t;

	localparam word_t FULL_WORD = {WORD_W{1'b1}};
	localparam word_t ZERO_WORD = '0;

	localparam mode_t MODE_RGB          = 3'd0;
	localparam mode_t MODE_RED          = 3'd1;
	localparam mode_t MODE_GREEN        = 3'd2;
	localparam mode_t MODE_BLUE         = 3'd3;
	localparam mode_t MODE_PSEUDO_RED   = 3'd4;
	localparam mode_t MODE_PSEUDO_GREEN = 3'd5;
	localparam mode_t MODE_PSEUDO_BLUE  = 3'd6;

	localparam sector_t SECTOR_RED_YELLOW    = 3'd0;
	localparam sector_t SECTOR_YELLOW_GREEN  = 3'd1;
	localparam sector_t SECTOR_GREEN_CYAN    = 3'd2;
	localparam sector_t SECTOR_CYAN_BLUE     = 3'd3;
	localparam sector_t SECTOR_BLUE_MAGENTA  = 3'd4;
	localparam sector_t SECTOR_MAGENTA_RED   = 3'd5;

	typedef struct packed {
		word_t red;
		word_t green;
		word_t blue;
	} rgb_t;

	// Full-saturation hue of a value. With t = 6*v = q*65536 + r, the floor
	// of t/65535 is q, plus one when q + r reaches 65535.
	function automatic rgb_t hue_map(input word_t v);
		logic [WORD_W+2:0] t;
		sector_t           q;
		logic [WORD_W:0]   sum;
		sector_t           sector;
		word_t             frac;
		word_t             rise;
		word_t             fall;
		rgb_t              c;
		t = ({3'b000, v} << 2) + ({3'b000, v} << 1);
		q = t[WORD_W+2:WORD_W];
		sum = {1'b0, t[WORD_W-1:0]} + {{(WORD_W-SECTOR_W+1){1'b0}}, q};
		if (sum >= {1'b0, FULL_WORD}) begin
			sector = q + sector_t'(1);
			frac = word_t'(sum - {1'b0, FULL_WORD});
		end else begin
			sector = q;
			frac = sum[WORD_W-1:0];
		end
		// The top input value lands past the last sector and wraps to red.
		if (sector > SECTOR_MAGENTA_RED) begin
			sector = SECTOR_RED_YELLOW;
			frac = ZERO_WORD;
		end
		rise = frac;
		fall = FULL_WORD - frac;
		case (sector)
			SECTOR_RED_YELLOW:   c = '{red: FULL_WORD, green: rise, blue: ZERO_WORD};
			SECTOR_YELLOW_GREEN: c = '{red: fall, green: FULL_WORD, blue: ZERO_WORD};
			SECTOR_GREEN_CYAN:   c = '{red: ZERO_WORD, green: FULL_WORD, blue: rise};
			SECTOR_CYAN_BLUE:    c = '{red: ZERO_WORD, green: fall, blue: FULL_WORD};
			SECTOR_BLUE_MAGENTA: c = '{red: rise, green: ZERO_WORD, blue: FULL_WORD};
			default:             c = '{red: FULL_WORD, green: ZERO_WORD, blue: fall};
		endcase
		return c;
	endfunction

endpackage

// ===== sv/pdcm_if.sv =====
// ----------------------------------------------------------------------------
// pdcm_if
// Request channels of the display color mapper: input pixel and display pixel.
// ----------------------------------------------------------------------------
interface pdcm_pixel_if;
	import pdcm_pkg::*;

	logic  valid;
	logic  ready;
	word_t red_sample;
	word_t green_sample;
	word_t blue_sample;

	modport source (output valid, output red_sample, output green_sample,
		output blue_sample, input ready);
	modport sink (input valid, input red_sample, input green_sample,
		input blue_sample, output ready);
endinterface

interface pdcm_display_if;
	import pdcm_pkg::*;

	logic  valid;
	logic  ready;
	word_t out_blue;
	word_t out_green;
	word_t out_red;
	word_t out_alpha;

	modport source (output valid, output out_blue, output out_green,
		output out_red, output out_alpha, input ready);
	modport sink (input valid, input out_blue, input out_green,
		input out_red, input out_alpha, output ready);
endinterface

// ===== sv/pixel_display_color_mapper.sv =====
// ----------------------------------------------------------------------------
// pixel_display_color_mapper: 16-bit RGB pixel to BGRA display pixel mapper.
// An accepted request passes through the input register and then the result register to the display port.
// Throughput is one pixel per cycle while the display takes results; a stalled display holds both registers.
// Reset clears the valid bits and sets the display mode to rgb pass-through.
// ----------------------------------------------------------------------------
module pixel_display_color_mapper (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  pdcm_pkg::mode_t     cfg_wdata,
	pdcm_pixel_if.sink          pixel,
	pdcm_display_if.source      display
);
	import pdcm_pkg::*;

	mode_t mode_q;

	logic  valid_s1;
	word_t red_s1;
	word_t green_s1;
	word_t blue_s1;

	logic  valid_s2;
	rgb_t  color_s2;
	logic  grey_s2;
	logic  pseudo_s2;

	logic  adv_s2;
	logic  adv_s1;
	rgb_t  color_d;
	logic  grey_d;
	logic  pseudo_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RGB;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// The result register frees up whenever it is empty or being drained.
	assign adv_s2 = !valid_s2 || display.ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pixel.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pixel.valid) begin
			red_s1 <= pixel.red_sample;
			green_s1 <= pixel.green_sample;
			blue_s1 <= pixel.blue_sample;
		end
	end

	always_comb begin
		grey_d = mode_q inside {MODE_RED, MODE_GREEN, MODE_BLUE};
		pseudo_d = mode_q inside {MODE_PSEUDO_RED, MODE_PSEUDO_GREEN, MODE_PSEUDO_BLUE};
		case (mode_q)
			MODE_RGB:          color_d = '{red: red_s1, green: green_s1, blue: blue_s1};
			MODE_RED:          color_d = '{red: red_s1, green: red_s1, blue: red_s1};
			MODE_GREEN:        color_d = '{red: green_s1, green: green_s1, blue: green_s1};
			MODE_BLUE:         color_d = '{red: blue_s1, green: blue_s1, blue: blue_s1};
			MODE_PSEUDO_RED:   color_d = hue_map(red_s1);
			MODE_PSEUDO_GREEN: color_d = hue_map(green_s1);
			MODE_PSEUDO_BLUE:  color_d = hue_map(blue_s1);
			default:           color_d = '{red: ZERO_WORD, green: ZERO_WORD, blue: ZERO_WORD};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			color_s2 <= color_d;
			grey_s2 <= grey_d;
			pseudo_s2 <= pseudo_d;
		end
	end

	assign display.valid = valid_s2;
	assign display.out_blue = color_s2.blue;
	assign display.out_green = color_s2.green;
	assign display.out_red = color_s2.red;
	assign display.out_alpha = FULL_WORD;

`ifndef SYNTHESIS
	// A pixel held in the input register must not move while the result waits.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !display.ready |=>
			valid_s1 && $stable(red_s1) && $stable(green_s1) && $stable(blue_s1))
		else $error("input stage changed while the result was stalled");

	// Grey modes drive the same word on all three color channels.
	a_grey_equal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && grey_s2 |->
			color_s2.red == color_s2.green && color_s2.green == color_s2.blue)
		else $error("grey result has unequal color words");

	// A full-saturation hue always has one channel at full and one at zero.
	a_hue_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && pseudo_s2 |->
			(color_s2.red == FULL_WORD || color_s2.green == FULL_WORD ||
			 color_s2.blue == FULL_WORD) &&
			(color_s2.red == ZERO_WORD || color_s2.green == ZERO_WORD ||
			 color_s2.blue == ZERO_WORD))
		else $error("pseudo color result is not fully saturated");
`endif

endmodule

// ===== dv/tb_pixel_display_color_mapper.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_display_color_mapper
// Drives RGB pixels through the display color mapper under every display
// mode, with random gaps on the pixel side and random stalls on the display
// side, and checks each BGRA result against an independent predictor.
// ----------------------------------------------------------------------------
module tb_pixel_display_color_mapper;
	import pdcm_pkg::*;

	localparam mode_t       MODE_UNUSED = 3'd7;
	localparam int unsigned PIXEL_TARGET = 1050;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		word_t blue;
		word_t green;
		word_t red;
		word_t alpha;
	} bgra_t;

	// Holds the display pixels that the accepted input pixels must produce.
	class bgra_tracker;
		bgra_t       pending_bgra[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		function int unsigned pending();
			return pending_bgra.size();
		endfunction

		function bgra_t colorize(mode_t mode, word_t r, word_t g, word_t b);
			int unsigned v;
			int unsigned t;
			int unsigned sector;
			int unsigned frac;
			word_t       rise;
			word_t       fall;
			bgra_t       px;
			px = '{blue: ZERO_WORD, green: ZERO_WORD, red: ZERO_WORD, alpha: FULL_WORD};
			v = 0;
			case (mode)
				MODE_RGB: begin
					px.red = r;
					px.green = g;
					px.blue = b;
				end
				MODE_RED:   px = '{blue: r, green: r, red: r, alpha: FULL_WORD};
				MODE_GREEN: px = '{blue: g, green: g, red: g, alpha: FULL_WORD};
				MODE_BLUE:  px = '{blue: b, green: b, red: b, alpha: FULL_WORD};
				MODE_PSEUDO_RED, MODE_PSEUDO_GREEN, MODE_PSEUDO_BLUE: begin
					if (mode == MODE_PSEUDO_RED)
						v = {16'd0, r};
					else if (mode == MODE_PSEUDO_GREEN)
						v = {16'd0, g};
					else
						v = {16'd0, b};
					t = 6 * v;
					sector = t / 65535;
					frac = t - sector * 65535;
					// Only the top value reaches a seventh sector; it is pure red.
					if (sector >= 6) begin
						sector = 0;
						frac = 0;
					end
					rise = word_t'(frac);
					fall = FULL_WORD - rise;
					case (sector_t'(sector))
						SECTOR_RED_YELLOW: begin
							px.red = FULL_WORD; px.green = rise; px.blue = ZERO_WORD;
						end
						SECTOR_YELLOW_GREEN: begin
							px.red = fall; px.green = FULL_WORD; px.blue = ZERO_WORD;
						end
						SECTOR_GREEN_CYAN: begin
							px.red = ZERO_WORD; px.green = FULL_WORD; px.blue = rise;
						end
						SECTOR_CYAN_BLUE: begin
							px.red = ZERO_WORD; px.green = fall; px.blue = FULL_WORD;
						end
						SECTOR_BLUE_MAGENTA: begin
							px.red = rise; px.green = ZERO_WORD; px.blue = FULL_WORD;
						end
						default: begin
							px.red = FULL_WORD; px.green = ZERO_WORD; px.blue = fall;
						end
					endcase
				end
				default: ;
			endcase
			return px;
		endfunction

		function void note_pixel(mode_t mode, word_t r, word_t g, word_t b);
			pending_bgra.push_back(colorize(mode, r, g, b));
		endfunction

		function void check_display(word_t b, word_t g, word_t r, word_t a);
			bgra_t seen;
			bgra_t want;
			seen = '{blue: b, green: g, red: r, alpha: a};
			if (pending_bgra.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: display pixel b=%h g=%h r=%h a=%h with no request pending",
						$time, b, g, r, a);
			end else begin
				want = pending_bgra.pop_front();
				if (seen !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: expected b=%h g=%h r=%h a=%h, got b=%h g=%h r=%h a=%h",
							$time, want.blue, want.green, want.red, want.alpha,
							b, g, r, a);
				end
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	mode_t cfg_wdata;

	pdcm_pixel_if   pixel();
	pdcm_display_if display();

	bgra_tracker tracker = new();
	mode_t       active_mode;
	int unsigned pixels_sent;

	pixel_display_color_mapper i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pixel     (pixel),
		.display   (display)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned gap_cycles();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Channel values lean toward the extremes and the hue sector borders.
	function automatic word_t pick_word();
		int k;
		int v;
		case ($urandom_range(0, 7))
			0: return ZERO_WORD;
			1: return FULL_WORD;
			2, 3: begin
				k = $urandom_range(1, 6);
				v = (k * 65535) / 6 + int'($urandom_range(0, 4)) - 2;
				if (v > 65535)
					v = 65535;
				return word_t'(v);
			end
			default: return word_t'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input word_t r, input word_t g, input word_t b, input bit steady);
		int unsigned gap;
		pixel.valid <= 1'b1;
		pixel.red_sample <= r;
		pixel.green_sample <= g;
		pixel.blue_sample <= b;
		do
			@(posedge clk);
		while (pixel.ready !== 1'b1);
		tracker.note_pixel(active_mode, r, g, b);
		pixels_sent++;
		gap = steady ? 0 : gap_cycles();
		if (gap != 0) begin
			pixel.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		pixel.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mode(input mode_t mode);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_mode = mode;
	endtask

	// Display side: random stalls, with stretches in which no new stall begins.
	initial begin
		int unsigned stall_left;
		int unsigned stretch_left;
		bit          relaxed;
		stall_left = 0;
		stretch_left = 0;
		relaxed = 1'b0;
		display.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && display.valid === 1'b1 && display.ready === 1'b1)
				tracker.check_display(display.out_blue, display.out_green,
					display.out_red, display.out_alpha);
			if (stretch_left == 0) begin
				relaxed = ($urandom_range(0, 3) == 0);
				stretch_left = $urandom_range(50, 300);
			end else begin
				stretch_left--;
			end
			if (stall_left == 0 && !relaxed && $urandom_range(0, 3) == 0)
				stall_left = gap_cycles();
			display.ready <= (stall_left == 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	initial begin
		word_t       borders[12];
		mode_t       mode_order[8];
		mode_t       mode;
		int unsigned phase;
		int unsigned count;
		bit          steady;

		borders = '{16'd0, 16'd65535, 16'd65534, 16'd1, 16'd10922, 16'd10923,
			16'd21845, 16'd32767, 16'd32768, 16'd43690, 16'd54612, 16'd54613};
		mode_order = '{MODE_PSEUDO_BLUE, MODE_UNUSED, MODE_RGB, MODE_PSEUDO_GREEN,
			MODE_RED, MODE_GREEN, MODE_PSEUDO_RED, MODE_BLUE};

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= MODE_RGB;
		pixel.valid <= 1'b0;
		pixel.red_sample <= ZERO_WORD;
		pixel.green_sample <= ZERO_WORD;
		pixel.blue_sample <= ZERO_WORD;
		active_mode = MODE_RGB;
		pixels_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hue sector borders, the top value and zero on the red channel.
		set_mode(MODE_PSEUDO_RED);
		for (int i = 0; i < 12; i++)
			send_pixel(borders[i], borders[11 - i], borders[(i + 4) % 12], 1'b0);
		// Extremes on red and green and exact sector borders on blue, in every mode but pseudo red.
		for (int i = 0; i < 8; i++) begin
			if (mode_order[i] == MODE_PSEUDO_RED)
				continue;
			set_mode(mode_order[i]);
			send_pixel(FULL_WORD, ZERO_WORD, 16'hAAAA, 1'b1);
			send_pixel(ZERO_WORD, FULL_WORD, 16'h5555, 1'b0);
		end

		phase = 0;
		while (pixels_sent < PIXEL_TARGET) begin
			if (phase < 8)
				mode = mode_order[phase];
			else
				mode = mode_order[$urandom_range(0, 7)];
			set_mode(mode);
			count = $urandom_range(30, 90);
			steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < count; i++) begin
				// Hold off new requests until the output side has caught up.
				if (i == count / 2 && (phase == 2 || $urandom_range(0, 2) == 0))
					drain();
				send_pixel(pick_word(), pick_word(), pick_word(), steady);
			end
			phase++;
		end

		pixel.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("tb_pixel_display_color_mapper: PASS");
		else
			$display("tb_pixel_display_color_mapper: FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tb_pixel_display_color_mapper: FAIL");
		$finish;
	end

endmodule
